/* hdl/rlpm_pkg.sv */
package rlpm_pkg;

    // descriptor packing
    localparam int DESC_W      = 40;
    localparam int DESC_COUNT  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int SLOT_W      = 16;
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 8;
    localparam int ACTION_W    = 2;
    localparam int PART_W      = 2;
    localparam int STATUS_W    = 2;

    localparam int PARTITION_COUNT_DEF = 4;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NEWEST = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LENGTH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOTS = 2'd2;

    // pointer reduction sequencer
    typedef enum logic [1:0] {
        RED_IDLE,
        RED_WRITE_SLOT,
        RED_READ_SLOT
    } red_state_t;

    // pointers that must be reduced before the step can finish
    typedef struct packed {
        logic w;
        logic r;
    } calc_need_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [SLOT_W-1:0]   w;
        logic [SLOT_W-1:0]   r;
        logic [SLOT_W-1:0]   u;
        logic                write;
    } calc_result_t;

    function automatic logic [ADDR_W-1:0] desc_start(input logic [DESC_W-1:0] d);
        return d[15:0];
    endfunction

    function automatic logic [SIZE_W-1:0] desc_size(input logic [DESC_W-1:0] d);
        return d[23:16];
    endfunction

    function automatic logic [SLOT_W-1:0] desc_slots(input logic [DESC_W-1:0] d);
        return d[39:24];
    endfunction

endpackage

/* hdl/rlpm_rem.sv */
// bit-serial restoring remainder, one dividend bit per cycle
module rlpm_rem
    import rlpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SLOT_W-1:0] dividend,
    input  logic [SLOT_W-1:0] divisor,
    output logic              done,
    output logic [SLOT_W-1:0] result
);

    localparam int CNT_W = $clog2(SLOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] dvd_reg;
    logic [SLOT_W-1:0] div_reg;
    logic [SLOT_W-1:0] rem_reg;

    logic [SLOT_W:0]   trial;
    logic [SLOT_W:0]   diff;
    logic [SLOT_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SLOT_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(SLOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SLOT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

/* hdl/rlpm_calc.sv */
// one request against one partition's pointers and descriptor
module rlpm_calc
    import rlpm_pkg::*;
(
    input  logic [ACTION_W-1:0] action,
    input  logic                in_range,
    input  logic [SIZE_W-1:0]   record_length,
    input  logic [DESC_W-1:0]   desc,
    input  logic [SLOT_W-1:0]   w,
    input  logic [SLOT_W-1:0]   r,
    input  logic [SLOT_W-1:0]   u,
    input  logic [SLOT_W-1:0]   w_red,
    input  logic [SLOT_W-1:0]   r_red,
    output calc_need_t          need,
    output calc_result_t        res
);

    logic [ADDR_W-1:0]        start;
    logic [SIZE_W-1:0]        size;
    logic [SLOT_W-1:0]        slots;
    logic                     len_bad;
    logic                     zero_bad;
    logic                     ok;
    logic [SLOT_W:0]          w_inc;
    logic [SLOT_W:0]          r_inc;
    logic [SLOT_W-1:0]        w_step;
    logic [SLOT_W-1:0]        r_step;
    logic                     u_full;
    logic [SLOT_W-1:0]        back;
    logic [SLOT_W-1:0]        back_c;
    logic [SLOT_W:0]          back_sum;
    logic [SLOT_W:0]          back_wrap;
    logic [SLOT_W-1:0]        newest;
    logic [SLOT_W-1:0]        mul_slot;
    logic [SIZE_W+SLOT_W-1:0] product;
    logic [ADDR_W-1:0]        addr_raw;

    always_comb
    begin
        start    = desc_start(desc);
        size     = desc_size(desc);
        slots    = desc_slots(desc);
        len_bad  = (action != ACT_QUERY) && (record_length != size);
        zero_bad = (action != ACT_QUERY) && (slots == '0);
        ok       = in_range && !len_bad && !zero_bad;

        // wrap forward, operands already below the slot count
        w_inc  = {1'b0, w_red} + 1'b1;
        r_inc  = {1'b0, r_red} + 1'b1;
        w_step = (w_inc == {1'b0, slots}) ? '0 : w_inc[SLOT_W-1:0];
        r_step = (r_inc == {1'b0, slots}) ? '0 : r_inc[SLOT_W-1:0];
        u_full = (u >= slots);

        // newest unread slot, one step back at least
        back      = (u == '0) ? SLOT_W'(1) : u;
        back_c    = (back > slots) ? slots : back;
        back_sum  = {1'b0, w_red} + {1'b0, slots} - {1'b0, back_c};
        back_wrap = back_sum - {1'b0, slots};
        newest    = (back_sum >= {1'b0, slots}) ? back_wrap[SLOT_W-1:0]
                                                : back_sum[SLOT_W-1:0];

        mul_slot = (action == ACT_NEWEST) ? newest : w;
        product  = (SIZE_W+SLOT_W)'(size) * (SIZE_W+SLOT_W)'(mul_slot);
        addr_raw = start + product[ADDR_W-1:0];

        need.w = ok && ((action == ACT_COMMIT) || (action == ACT_NEWEST)) && (w >= slots);
        need.r = ok && (action == ACT_COMMIT) && u_full && (r >= slots);

        if (!in_range)
            res.status = ST_NO_SLOTS;
        else if (len_bad)
            res.status = ST_LENGTH;
        else if (zero_bad)
            res.status = ST_NO_SLOTS;
        else
            res.status = ST_OK;

        res.addr  = (ok && (action != ACT_QUERY)) ? addr_raw : '0;
        res.w     = in_range ? w : '0;
        res.r     = in_range ? r : '0;
        res.u     = in_range ? u : '0;
        res.write = 1'b0;

        if (ok && (action == ACT_COMMIT))
        begin
            res.w     = w_step;
            res.u     = u_full ? slots : (u + 1'b1);
            res.r     = u_full ? r_step : r;
            res.write = 1'b1;
        end
    end

endmodule

/* hdl/ring_log_pointer_manager.sv */
// Ring log pointer manager: holds the write slot, read slot and unread count of up to
// four circular record logs in external memory, each described by a 40-bit descriptor
// (start address 15:0, record size 23:16, slot count 39:24). A request word enters an
// input register and its result word leaves through an output register. One request
// per cycle is taken unless a pointer reduction or a stalled result holds the input
// register: a waiting result blocks the next request. Append and query requests never
// wait for a reduction. When a descriptor has been rewritten so that a stored write or
// read slot lies at or beyond the new slot count, a commit or newest-read request on that
// log first reduces the pointer through a shared bit-serial remainder unit, one pointer
// at a time, while the input stays stalled. Status 1 flags a record length
// that differs from the record size, status 2 a slot count of zero or a log that does
// not exist; on an error nothing changes and the address reads zero.
module ring_log_pointer_manager
    import rlpm_pkg::*;
#(
    parameter int PARTITION_COUNT = PARTITION_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DESC_W-1:0]      cfg_data,

    // request channel
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [ACTION_W-1:0]    action,
    input  logic [PART_W-1:0]      partition,
    input  logic [SIZE_W-1:0]      record_length,

    // result channel
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [ADDR_W-1:0]      record_address,
    output logic [SLOT_W-1:0]      write_slot,
    output logic [SLOT_W-1:0]      read_slot,
    output logic [SLOT_W-1:0]      unread_count
);

    // logs that have both a descriptor and pointer state
    localparam int LOG_COUNT = (PARTITION_COUNT < DESC_COUNT) ? PARTITION_COUNT : DESC_COUNT;
    localparam int LOG_IDX_W = (LOG_COUNT > 1) ? $clog2(LOG_COUNT) : 1;

    // descriptors and per-log pointers
    logic [DESC_W-1:0] desc_reg  [DESC_COUNT];
    logic [SLOT_W-1:0] wslot_reg [LOG_COUNT];
    logic [SLOT_W-1:0] rslot_reg [LOG_COUNT];
    logic [SLOT_W-1:0] unread_reg[LOG_COUNT];

    // input register
    logic                stg_valid_reg;
    logic [ACTION_W-1:0] stg_action_reg;
    logic [PART_W-1:0]   stg_partition_reg;
    logic [SIZE_W-1:0]   stg_length_reg;

    // pointer reduction
    red_state_t        red_state_reg;
    red_state_t        red_state_next;
    logic              w_fixed_reg;
    logic              r_fixed_reg;
    logic [SLOT_W-1:0] wm_reg;
    logic [SLOT_W-1:0] rm_reg;
    logic              rem_start;
    logic [SLOT_W-1:0] rem_operand;
    logic              rem_done;
    logic [SLOT_W-1:0] rem_result;

    // output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [SLOT_W-1:0]   out_w_reg;
    logic [SLOT_W-1:0]   out_r_reg;
    logic [SLOT_W-1:0]   out_u_reg;

    logic                in_range;
    logic [LOG_IDX_W-1:0] idx;
    logic [DESC_W-1:0]   desc_sel;
    logic [SLOT_W-1:0]   w_cur;
    logic [SLOT_W-1:0]   r_cur;
    logic [SLOT_W-1:0]   u_cur;
    logic [SLOT_W-1:0]   w_red;
    logic [SLOT_W-1:0]   r_red;
    calc_need_t          need;
    calc_result_t        res;
    logic                red_clear;
    logic                finish;
    logic                req_take;
    logic                state_we;

    // select the addressed log
    always_comb
    begin
        in_range = (32'(stg_partition_reg) < LOG_COUNT);
        idx      = in_range ? stg_partition_reg[LOG_IDX_W-1:0] : '0;
        desc_sel = desc_reg[stg_partition_reg];
        w_cur    = wslot_reg[idx];
        r_cur    = rslot_reg[idx];
        u_cur    = unread_reg[idx];
        w_red    = w_fixed_reg ? wm_reg : w_cur;
        r_red    = r_fixed_reg ? rm_reg : r_cur;
    end

    rlpm_calc u_calc (
        .action        (stg_action_reg),
        .in_range      (in_range),
        .record_length (stg_length_reg),
        .desc          (desc_sel),
        .w             (w_cur),
        .r             (r_cur),
        .u             (u_cur),
        .w_red         (w_red),
        .r_red         (r_red),
        .need          (need),
        .res           (res)
    );

    rlpm_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_operand),
        .divisor  (desc_slots(desc_sel)),
        .done     (rem_done),
        .result   (rem_result)
    );

    // the step may finish once every out-of-range pointer is reduced
    assign red_clear = (red_state_reg == RED_IDLE)
                     && !(need.w && !w_fixed_reg)
                     && !(need.r && !r_fixed_reg);
    assign finish    = stg_valid_reg && red_clear && (!out_valid_reg || !rsp_stall);
    assign req_stall = stg_valid_reg && !finish;
    assign req_take  = req_valid && !req_stall;
    assign state_we  = finish && res.write;

    // reduction sequencer: next state
    always_comb
    begin
        red_state_next = red_state_reg;
        unique case (red_state_reg)
            RED_IDLE:
            begin
                if (stg_valid_reg && need.w && !w_fixed_reg)
                    red_state_next = RED_WRITE_SLOT;
                else if (stg_valid_reg && need.r && !r_fixed_reg)
                    red_state_next = RED_READ_SLOT;
            end
            RED_WRITE_SLOT:
            begin
                if (rem_done)
                    red_state_next = RED_IDLE;
            end
            RED_READ_SLOT:
            begin
                if (rem_done)
                    red_state_next = RED_IDLE;
            end
            default:
                red_state_next = RED_IDLE;
        endcase
    end

    // reduction sequencer: outputs
    always_comb
    begin
        rem_start   = 1'b0;
        rem_operand = w_cur;
        unique case (red_state_reg) inside
            RED_IDLE:
            begin
                if (stg_valid_reg && need.w && !w_fixed_reg)
                begin
                    rem_start   = 1'b1;
                    rem_operand = w_cur;
                end
                else if (stg_valid_reg && need.r && !r_fixed_reg)
                begin
                    rem_start   = 1'b1;
                    rem_operand = r_cur;
                end
            end
            RED_WRITE_SLOT,
            RED_READ_SLOT:
            begin
                rem_start = 1'b0;
            end
            default:
                rem_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_state_reg <= RED_IDLE;
            w_fixed_reg   <= 1'b0;
            r_fixed_reg   <= 1'b0;
        end
        else
        begin
            red_state_reg <= red_state_next;
            if (finish)
            begin
                w_fixed_reg <= 1'b0;
                r_fixed_reg <= 1'b0;
            end
            else if (rem_done && (red_state_reg == RED_WRITE_SLOT))
                w_fixed_reg <= 1'b1;
            else if (rem_done && (red_state_reg == RED_READ_SLOT))
                r_fixed_reg <= 1'b1;
        end
    end

    // reduced pointer values
    always_ff @(posedge clk)
    begin
        if (rem_done && (red_state_reg == RED_WRITE_SLOT))
            wm_reg <= rem_result;
        if (rem_done && (red_state_reg == RED_READ_SLOT))
            rm_reg <= rem_result;
    end

    // descriptors and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DESC_COUNT; i++)
                desc_reg[i] <= '0;
            for (int i = 0; i < LOG_COUNT; i++)
            begin
                wslot_reg[i]  <= '0;
                rslot_reg[i]  <= '0;
                unread_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
                desc_reg[cfg_index] <= cfg_data;
            if (state_we)
            begin
                wslot_reg[idx]  <= res.w;
                rslot_reg[idx]  <= res.r;
                unread_reg[idx] <= res.u;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (req_take)
            stg_valid_reg <= 1'b1;
        else if (finish)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            stg_action_reg    <= action;
            stg_partition_reg <= partition;
            stg_length_reg    <= record_length;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_status_reg <= res.status;
            out_addr_reg   <= res.addr;
            out_w_reg      <= res.w;
            out_r_reg      <= res.r;
            out_u_reg      <= res.u;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign record_address = out_addr_reg;
    assign write_slot     = out_w_reg;
    assign read_slot      = out_r_reg;
    assign unread_count   = out_u_reg;

`ifndef NO_ASSERTIONS
    // a committed write slot always lands inside the ring
    a_commit_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        state_we |-> (res.w < desc_slots(desc_sel)))
        else $error("committed write slot outside the ring");

    // reduction only runs on behalf of a held request
    a_red_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        (red_state_reg != RED_IDLE) |-> stg_valid_reg)
        else $error("pointer reduction without a request");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall) |-> !finish)
        else $error("result overwritten while stalled");
`endif

endmodule
